// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the key matrix event unit.
// No dependencies; expects clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define KMCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked property that also holds during reset.
`define KMCE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/kmce_pkg.sv
// Package for the key matrix event unit: matrix geometry, scan remap and keymap ROM.
// No dependencies.
package kmce_pkg;

  localparam int unsigned DriveLines = 8;
  localparam int unsigned SenseLines = 7;
  localparam int unsigned KeyCols    = 14;
  localparam int unsigned KeyCount   = DriveLines * SenseLines;
  localparam int unsigned IdxW       = $clog2(KeyCount);
  localparam int unsigned CodeW      = 7;

  typedef logic [KeyCount-1:0] key_map_t;
  typedef logic [IdxW-1:0]     key_idx_t;
  typedef logic [CodeW-1:0]    key_code_t;

  // Turn active-low raw sense levels into the pressed map in key-index order.
  function automatic key_map_t scan_to_map(input logic [KeyCount-1:0] raw);
    key_map_t    map;
    int unsigned krow;
    int unsigned kcol;
    map = '0;
    for (int unsigned r = 0; r < DriveLines; r++) begin
      for (int unsigned c = 0; c < SenseLines; c++) begin
        krow = 3 - (r & 3);
        kcol = c * 2 + (((r & 4) != 0) ? 0 : 1);
        map[krow * KeyCols + kcol] = ~raw[r * SenseLines + c];
      end
    end
    return map;
  endfunction

  function automatic key_code_t key_rom(input key_idx_t idx);
    key_code_t code;
    case (idx)
      6'd0:  code = 7'h60;
      6'd1:  code = 7'h31;
      6'd2:  code = 7'h32;
      6'd3:  code = 7'h33;
      6'd4:  code = 7'h34;
      6'd5:  code = 7'h35;
      6'd6:  code = 7'h36;
      6'd7:  code = 7'h37;
      6'd8:  code = 7'h38;
      6'd9:  code = 7'h39;
      6'd10: code = 7'h30;
      6'd11: code = 7'h2d;
      6'd12: code = 7'h3d;
      6'd13: code = 7'h01;
      6'd14: code = 7'h02;
      6'd15: code = 7'h71;
      6'd16: code = 7'h77;
      6'd17: code = 7'h65;
      6'd18: code = 7'h72;
      6'd19: code = 7'h74;
      6'd20: code = 7'h79;
      6'd21: code = 7'h75;
      6'd22: code = 7'h69;
      6'd23: code = 7'h6f;
      6'd24: code = 7'h70;
      6'd25: code = 7'h5b;
      6'd26: code = 7'h5d;
      6'd27: code = 7'h5c;
      6'd28: code = 7'h03;
      6'd29: code = 7'h04;
      6'd30: code = 7'h61;
      6'd31: code = 7'h73;
      6'd32: code = 7'h64;
      6'd33: code = 7'h66;
      6'd34: code = 7'h67;
      6'd35: code = 7'h68;
      6'd36: code = 7'h6a;
      6'd37: code = 7'h6b;
      6'd38: code = 7'h6c;
      6'd39: code = 7'h3b;
      6'd40: code = 7'h27;
      6'd41: code = 7'h05;
      6'd42: code = 7'h06;
      6'd43: code = 7'h07;
      6'd44: code = 7'h08;
      6'd45: code = 7'h7a;
      6'd46: code = 7'h78;
      6'd47: code = 7'h63;
      6'd48: code = 7'h76;
      6'd49: code = 7'h62;
      6'd50: code = 7'h6e;
      6'd51: code = 7'h6d;
      6'd52: code = 7'h2c;
      6'd53: code = 7'h2e;
      6'd54: code = 7'h2f;
      6'd55: code = 7'h20;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/key_matrix_change_events_unit.sv
// Key matrix change event unit: walks the changed-key mask of each scan and emits events.
// Depends on kmce_pkg and assert_macros.svh.
//
//   channel  | direction | payload                                  | handshake
//   ---------+-----------+------------------------------------------+----------------------
//   scan in  | input     | raw_levels_i (56 b, active low)          | in_valid_i/in_stall_o
//   events   | output    | pressed_o, key_code_o, key_index_o, last_o | out_valid_o/out_stall_i
//
// A scan is taken while idle; a shift sequencer then steps one key index per cycle
// (holding at a changed key while the output is stalled) and stops after the highest
// changed key, holding the input until then. An unchanged scan never stalls the input.
// Reset clears the pressed map (no key down), the sequencer and the output valid.
// A stalled event holds the output register; the walk waits on it only at changed keys.
`include "assert_macros.svh"

module key_matrix_change_events_unit
  import kmce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KeyCount-1:0] raw_levels_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                pressed_o,
  output logic [CodeW-1:0]    key_code_o,
  output logic [IdxW-1:0]     key_index_o,
  output logic                last_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic      state_q, state_d;
  key_map_t  map_q, map_d;
  key_map_t  diff_q, diff_d;
  key_idx_t  idx_q, idx_d;
  logic      out_valid_q, out_valid_d;
  logic      pressed_q, pressed_d;
  key_code_t code_q, code_d;
  key_idx_t  oidx_q, oidx_d;
  logic      last_q, last_d;

  key_map_t  scan_map;
  logic      in_accept;
  logic      out_free;
  logic      pending;
  logic      remain;
  logic      load;

  assign scan_map  = scan_to_map(raw_levels_i);
  assign in_stall_o = (state_q == StWalk);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pending   = diff_q[0];
  assign remain    = |diff_q[KeyCount-1:1];
  assign load      = (state_q == StWalk) && pending && out_free;

  always_comb begin
    state_d     = state_q;
    map_d       = map_q;
    diff_d      = diff_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    pressed_d   = pressed_q;
    code_d      = code_q;
    oidx_d      = oidx_q;
    last_d      = last_q;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          map_d  = scan_map;
          diff_d = scan_map ^ map_q;
          idx_d  = '0;
          if ((scan_map ^ map_q) != '0) begin
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        // Advance past unchanged keys freely; hold on a changed key until the slot frees.
        if (!pending || out_free) begin
          diff_d = diff_q >> 1;
          idx_d  = idx_q + 1'b1;
          if (pending) begin
            out_valid_d = 1'b1;
            pressed_d   = map_q[idx_q];
            code_d      = key_rom(idx_q);
            oidx_d      = idx_q;
            last_d      = !remain;
            if (!remain) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      map_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      map_q       <= map_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q    <= diff_d;
    idx_q     <= idx_d;
    pressed_q <= pressed_d;
    code_q    <= code_d;
    oidx_q    <= oidx_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign pressed_o   = pressed_q;
  assign key_code_o  = code_q;
  assign key_index_o = oidx_q;
  assign last_o      = last_q;

  `KMCE_ASSERT(a_walk_has_work, (state_q == StWalk) |-> (diff_q != '0), "walk with empty mask")
  `KMCE_ASSERT(a_walk_in_range, (state_q == StWalk) |-> (idx_q < IdxW'(KeyCount)), "index out of range")
  `KMCE_ASSERT(a_last_ends_walk, (load && !remain) |=> (state_q == StIdle && out_valid_q && last_q), "last event did not end walk")
  `KMCE_ASSERT(a_map_update, in_accept |=> (map_q == $past(scan_map)), "pressed map not updated")
  // Uses |=>, as the first edge in reset may still see power-up values.
  `KMCE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == StIdle && !out_valid_q), "not idle in reset")

endmodule
